// ===== sv/wmf_pkg.sv =====
// shared types and defaults for the windowed median filter
// controller/datapath command and status structs; no dependencies

package wmf_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_RADIUS = 3;

    localparam int CFG_W = 12;   // widest configuration register
    localparam int ROW_W = 12;   // row counter width
    localparam int PIX_W = 8;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd512;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd512;
    localparam logic [1:0]       RST_RADIUS = 2'd2;

    typedef struct packed {
        logic accept;     // take the input transaction
        logic start_x;    // set up selection for the current output column
        logic elem_read;  // fetch next window element from the line store
        logic decide;     // settle one bit of the median
        logic load_out;   // move the median into the output register
        logic next_x;     // step to the next output column
    } wmf_cmd_t;

    typedef struct packed {
        logic go;         // accepted pixel produces output
        logic last_elem;  // final window element being fetched
        logic bit_zero;   // deciding the lsb
        logic x_last;     // last output column of this transaction
        logic out_free;   // output register can take a value
    } wmf_sts_t;

endpackage

// ===== sv/wmf_ctrl.sv =====
// sequencer for the windowed median filter
// drives datapath commands from status; depends on wmf_pkg

module wmf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wmf_pkg::wmf_sts_t sts,
    output wmf_pkg::wmf_cmd_t cmd
);
    import wmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && sts.go) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.start_x = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ: begin
                cmd.elem_read = 1'b1;
                if (sts.last_elem) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.bit_zero ? ST_OUT : ST_READ;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (sts.x_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_x = 1'b1;
                        state_next = ST_INIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_decide_from_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DECIDE |-> $past(state_reg) == ST_WAIT)
        else $error("decide without settle cycle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("output overwritten");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && sts.go |=> state_reg == ST_INIT)
        else $error("emission not started");

endmodule

// ===== sv/wmf_dp.sv =====
// datapath of the windowed median filter: config, counters, line store,
// bitwise radix select and output register; depends on wmf_pkg

module wmf_dp #(
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = wmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [wmf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_mode,
    input  logic [wmf_pkg::PIX_W-1:0] s_pixel_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [wmf_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_end_of_row,
    output logic                      m_end_of_frame,
    input  wmf_pkg::wmf_cmd_t         cmd,
    output wmf_pkg::wmf_sts_t         sts
);
    import wmf_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int NW    = $clog2(SLOTS * SLOTS + 1);
    localparam int AW    = SW + CW;

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [1:0]       radius_reg;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [1:0]       r_eff;

    always_comb begin
        if (width_reg == '0)                    w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)    w_eff = WW'(MAX_WIDTH);
        else                                    w_eff = WW'(width_reg);
        if (height_reg == '0)                   h_eff = ROW_W'(1);
        else if (height_reg > 12'd2048)         h_eff = 12'd2048;
        else                                    h_eff = height_reg;
        if (radius_reg == '0)                   r_eff = 2'd1;
        else if (32'(radius_reg) > MAX_RADIUS)  r_eff = 2'(MAX_RADIUS);
        else                                    r_eff = radius_reg;
    end

    // stream position
    logic [ROW_W-1:0] row_reg;
    logic [CW-1:0]    col_reg;
    logic [SW-1:0]    slot_reg;

    // per transaction emission context
    logic [ROW_W-1:0] y_reg, cur_row_reg;
    logic [SW-1:0]    cur_slot_reg;
    logic [CW-1:0]    x_reg, hi_reg;

    // selection state
    logic [SW-1:0]    wx_reg, wy_reg;
    logic [2:0]       bit_reg;
    logic [PIX_W-1:0] prefix_reg;
    logic [NW-1:0]    k_reg, cnt_reg;
    logic             rd_vld_reg;
    logic [PIX_W-1:0] mem_q;

    logic [PIX_W-1:0] mem [0:SLOTS*(2**CW)-1];

    // accept-time decode
    logic [CW-1:0]    c;
    logic             ignore, in_image, emit, last_col;
    logic [CW-1:0]    lo;
    logic [WW-1:0]    c_inc;
    logic [ROW_W:0]   row_inc;

    always_comb begin
        c        = (WW'(col_reg) >= w_eff) ? CW'(w_eff - WW'(1)) : col_reg;
        in_image = row_reg < h_eff;
        ignore   = in_image && s_mode;
        last_col = WW'(c) == w_eff - WW'(1);
        lo       = (c >= CW'(r_eff)) ? c - CW'(r_eff) : '0;
        emit     = (row_reg >= ROW_W'(r_eff)) && (last_col || (c >= CW'(r_eff)));
        c_inc    = WW'(c) + WW'(1);
        row_inc  = {1'b0, row_reg} + 1'b1;
    end

    // window element address
    logic [ROW_W+1:0] ty, ry_u;
    logic [ROW_W-1:0] ry;
    logic [WW+1:0]    tx, cx_u;
    logic [CW-1:0]    cx;
    logic [SW-1:0]    d, rslot;
    logic [AW-1:0]    raddr;
    logic [NW-1:0]    cnt_inc;
    logic [PIX_W-1:0] hi_mask;
    logic             match;
    logic [2*SW-1:0]  last_w;

    always_comb begin
        ty   = {2'b00, y_reg} + (ROW_W+2)'(wy_reg);
        ry_u = (ty < (ROW_W+2)'(r_eff)) ? '0 : ty - (ROW_W+2)'(r_eff);
        ry   = (ry_u > (ROW_W+2)'(h_eff - 1'b1)) ? h_eff - 1'b1 : ry_u[ROW_W-1:0];
        tx   = (WW+2)'(x_reg) + (WW+2)'(wx_reg);
        cx_u = (tx < (WW+2)'(r_eff)) ? '0 : tx - (WW+2)'(r_eff);
        cx   = (cx_u > (WW+2)'(w_eff - 1'b1)) ? CW'(w_eff - 1'b1) : cx_u[CW-1:0];
        d    = SW'(cur_row_reg - ry);
        rslot = (cur_slot_reg >= d) ? cur_slot_reg - d : cur_slot_reg + SW'(SLOTS) - d;
        raddr = {rslot, cx};
        hi_mask = ~((8'd2 << bit_reg) - 8'd1);
        match = ((mem_q & hi_mask) == (prefix_reg & hi_mask)) && !mem_q[bit_reg];
        cnt_inc = cnt_reg + NW'(rd_vld_reg && match);
        last_w  = {SW'({r_eff, 1'b0}), SW'({r_eff, 1'b0})};
    end

    assign sts.go        = !ignore && emit;
    assign sts.last_elem = {wy_reg, wx_reg} == last_w;
    assign sts.bit_zero  = bit_reg == 3'd0;
    assign sts.x_last    = x_reg == hi_reg;
    assign sts.out_free  = !m_valid || m_ready;

    // line store
    always_ff @(posedge aclk) begin
        if (cmd.accept && in_image && !s_mode) begin
            mem[{slot_reg, c}] <= s_pixel_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.elem_read) begin
            mem_q <= mem[raddr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept && !ignore) begin
            y_reg        <= row_reg - ROW_W'(r_eff);
            cur_row_reg  <= row_reg;
            cur_slot_reg <= slot_reg;
            x_reg        <= lo;
            hi_reg       <= last_col ? CW'(w_eff - 1'b1) : lo;
        end else if (cmd.next_x) begin
            x_reg <= x_reg + 1'b1;
        end
        if (cmd.start_x) begin
            prefix_reg <= '0;
            k_reg      <= NW'(2 * r_eff * (r_eff + 1));
        end else if (cmd.decide) begin
            if (k_reg >= cnt_reg) begin
                prefix_reg[bit_reg] <= 1'b1;
                k_reg               <= k_reg - cnt_reg;
            end
        end
        if (cmd.load_out) begin
            m_pixel_out    <= prefix_reg;
            m_end_of_row   <= WW'(x_reg) == w_eff - WW'(1);
            m_end_of_frame <= (WW'(x_reg) == w_eff - WW'(1)) && (y_reg == h_eff - 1'b1);
        end
    end

    // the window never reaches back more than 2*radius rows from the
    // transaction's own row, whose slot is cur_slot_reg, so the slot offset stays small
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            radius_reg <= RST_RADIUS;
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
            bit_reg    <= 3'd7;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.elem_read;
            if (cfg_we) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[1:0];
                    default: ;
                endcase
                if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                    cfg_index == REG_RADIUS) begin
                    row_reg  <= '0;
                    col_reg  <= '0;
                    slot_reg <= '0;
                end
            end else if (cmd.accept && !ignore) begin
                if (c_inc >= w_eff) begin
                    col_reg <= '0;
                    if (row_inc >= {1'b0, h_eff} + (ROW_W+1)'(r_eff)) begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end else begin
                        row_reg  <= row_inc[ROW_W-1:0];
                        slot_reg <= (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                    end
                end else begin
                    col_reg <= c_inc[CW-1:0];
                end
            end
            if (cmd.start_x || cmd.decide) begin
                wx_reg  <= '0;
                wy_reg  <= '0;
                cnt_reg <= '0;
            end else begin
                if (cmd.elem_read) begin
                    if (wx_reg == SW'({r_eff, 1'b0})) begin
                        wx_reg <= '0;
                        wy_reg <= wy_reg + 1'b1;
                    end else begin
                        wx_reg <= wx_reg + 1'b1;
                    end
                end
                cnt_reg <= cnt_inc;
            end
            if (cmd.start_x) begin
                bit_reg <= 3'd7;
            end else if (cmd.decide) begin
                bit_reg <= bit_reg - 1'b1;
            end
            if (cmd.load_out) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < SW'(SLOTS))
        else $error("line slot out of range");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cfg_we) |-> WW'(col_reg) < w_eff || $changed(width_reg))
        else $error("column past row end");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= SLOTS * SLOTS)
        else $error("selection count overflow");

endmodule

// ===== sv/windowed_median_filter.sv =====
// top level of the windowed median filter
// joins wmf_ctrl and wmf_dp; depends on wmf_pkg

// 2-d median filter over 8-bit grey pixels in raster order, window side 3, 5
// or 7 (window_radius 1..3), image edges replicated. results lag by radius rows
// and columns; the last pixel of a row flushes that row's pending outputs, and
// after the frame radius*frame_width drain transactions (s_mode = 1) flush the
// bottom rows. a transaction that yields no output leaves the filter idle and
// ready for the next one. each output pixel is found by an 8-pass bitwise radix
// select that re-reads the (2r+1)^2 window elements from the single-read line
// store, one per cycle. the line store has no reset and needs no clearing pass.
// the output register decouples the sides: the next input is taken while a
// result waits. configuration writes (cfg_we) restart the frame.

module windowed_median_filter #(
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = wmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [wmf_pkg::CFG_W-1:0] cfg_data,
    // pixel input transactions
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [wmf_pkg::PIX_W-1:0] s_pixel_in,
    // median output transactions
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [wmf_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_end_of_row,
    output logic                      m_end_of_frame
);
    import wmf_pkg::*;

    wmf_cmd_t cmd;
    wmf_sts_t sts;

    // sequencer: idle / fetch passes / output handoff
    wmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage, counters and selection arithmetic
    wmf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_mode         (s_mode),
        .s_pixel_in     (s_pixel_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule
